// ===== hdl/imh_pkg.sv =====
// Package with the payload types and code constants of the indexed min-heap.
package imh_pkg;

	localparam int ID_FIELD_W  = 10;
	localparam int KEY_FIELD_W = 32;
	localparam int COUNT_W     = 11;

	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_REMOVE = 3'd1;
	localparam logic [2:0] CMD_POP    = 3'd2;
	localparam logic [2:0] CMD_UPDATE = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_IGNORED = 2'd1;
	localparam logic [1:0] ST_EMPTY   = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	typedef struct packed {
		logic [2:0]             command;
		logic [ID_FIELD_W-1:0]  element_id;
		logic [KEY_FIELD_W-1:0] priority_key;
	} imh_in_t;

	typedef struct packed {
		logic [ID_FIELD_W-1:0] popped_id;
		logic [1:0]            status;
		logic [COUNT_W-1:0]    element_count;
	} imh_out_t;

endpackage

// ===== hdl/imh_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module imh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/indexed_min_heap.sv =====
// Top level of the indexed binary min-heap with element position map and key store.
//
//   channel   | direction | handshake             | payload
//   ----------+-----------+-----------------------+-------------------------------------
//   in        | input     | in_valid / in_ready   | in_data: command, element_id, key
//   out       | output    | out_valid / out_ready | out_data: popped_id, status, count
//
// One command is worked on at a time. Every heap step is a read of the heap RAM
// followed by a read of the key RAM, both registered reads: a sift-up level walks
// S_UP_CHK, S_UP_P, S_UP_K, a sift-down level S_DN_CHK, S_DN_A, S_DN_B, S_DN_C.
// A clear walks heap slots 1 to element_count and clears the position map of each
// element. After reset the block sweeps all NUM_IDS entries of the position map
// with in_ready low. A finished result waits in the output register while in_ready
// is high again; only the next result stalls on a full output register.
module indexed_min_heap #(
	parameter int NUM_IDS  = 1024,
	parameter int KEY_BITS = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  imh_pkg::imh_in_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output imh_pkg::imh_out_t out_data
);

	import imh_pkg::*;

	// Element index width and heap position width (positions run 1..NUM_IDS).
	localparam int ID_W  = $clog2(NUM_IDS);
	localparam int POS_W = $clog2(NUM_IDS + 1);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_DEC, S_TO_LAST, S_GET_EK, S_DN_CHK, S_DN_A, S_DN_B,
		S_DN_C, S_DN_L1, S_DN_L2, S_UP_CHK, S_UP_P, S_UP_K, S_PLACE, S_FIN
	} state_t;

	state_t state_q;

	logic [2:0]          cmd_q;
	logic [ID_W-1:0]     id_q;
	logic                id_ok_q;
	logic [KEY_BITS-1:0] key_q;
	logic [ID_W-1:0]     del_q;     // element being taken out
	logic [ID_W-1:0]     e_q;       // element being moved
	logic [KEY_BITS-1:0] ekey_q;    // its key
	logic [POS_W-1:0]    pos_q;     // current hole position
	logic [POS_W-1:0]    fill_q;
	logic [POS_W-1:0]    lim_q;     // heap size seen by the sift-down
	logic                upd_q;     // an update still owes its sift-up
	logic [ID_W-1:0]     a_q;
	logic [ID_W-1:0]     b_q;
	logic [KEY_BITS-1:0] ka_q;
	logic [POS_W:0]      idx_q;
	logic                rdv_s1;
	logic [1:0]          st_q;
	logic [ID_W-1:0]     popped_q;
	imh_out_t            out_q;
	logic                out_valid_q;

	logic             h_we;
	logic [POS_W-1:0] h_waddr;
	logic [ID_W-1:0]  h_wdata;
	logic [POS_W-1:0] h_raddr;
	logic [ID_W-1:0]  h_rdata;

	logic             p_we;
	logic [ID_W-1:0]  p_waddr;
	logic [POS_W-1:0] p_wdata;
	logic [ID_W-1:0]  p_raddr;
	logic [POS_W-1:0] p_rdata;

	logic                k_we;
	logic [ID_W-1:0]     k_waddr;
	logic [KEY_BITS-1:0] k_wdata;
	logic [ID_W-1:0]     k_raddr;
	logic [KEY_BITS-1:0] k_rdata;

	// Heap slots, element to position map, and element keys.
	imh_ram #(.WIDTH(ID_W), .DEPTH(NUM_IDS + 1)) u_heap_ram (
		.clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
		.raddr(h_raddr), .rdata(h_rdata)
	);

	imh_ram #(.WIDTH(POS_W), .DEPTH(NUM_IDS)) u_pos_ram (
		.clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
		.raddr(p_raddr), .rdata(p_rdata)
	);

	imh_ram #(.WIDTH(KEY_BITS), .DEPTH(NUM_IDS)) u_key_ram (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
		.raddr(k_raddr), .rdata(k_rdata)
	);

	// Decode helpers used while the position of the addressed element is on p_rdata.
	logic present;
	logic in_xfer;
	logic [POS_W:0] child;
	logic [POS_W:0] child_nx;
	logic [POS_W:0] lim_x;
	logic           b_wins;
	logic [ID_W-1:0]     ch_id;
	logic [KEY_BITS-1:0] ch_key;
	logic [POS_W-1:0]    ch_pos;
	logic                res_load;

	assign in_xfer  = in_valid && in_ready;
	assign present  = id_ok_q && (p_rdata != '0);
	assign child    = {pos_q, 1'b0};
	assign child_nx = child + (POS_W+1)'(1);
	assign lim_x    = {1'b0, lim_q};
	assign b_wins   = k_rdata < ka_q;
	assign ch_id    = b_wins ? b_q : a_q;
	assign ch_key   = b_wins ? k_rdata : ka_q;
	assign ch_pos   = b_wins ? child_nx[POS_W-1:0] : child[POS_W-1:0];

	// The result register loads once the clear sweep is over and the register is free.
	assign res_load = (state_q == S_FIN)
		&& !(cmd_q == CMD_CLEAR && (idx_q <= {1'b0, fill_q} || rdv_s1))
		&& (!out_valid_q || out_ready);

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// RAM port control for each state.
	always_comb begin
		h_we = 1'b0; h_waddr = pos_q; h_wdata = e_q; h_raddr = '0;
		p_we = 1'b0; p_waddr = e_q; p_wdata = pos_q; p_raddr = id_q;
		k_we = 1'b0; k_waddr = id_q; k_wdata = key_q; k_raddr = e_q;
		case (state_q)
			S_INIT: begin
				p_we    = 1'b1;
				p_waddr = idx_q[ID_W-1:0];
				p_wdata = '0;
			end
			S_IDLE: begin
				// Look up the addressed element and the heap root at once.
				p_raddr = ID_W'(in_data.element_id);
				h_raddr = POS_W'(1);
			end
			S_DEC: begin
				h_raddr = fill_q;
				if (cmd_q == CMD_REMOVE && present) begin
					p_we = 1'b1; p_waddr = id_q; p_wdata = '0;
				end else if (cmd_q == CMD_POP && fill_q != '0) begin
					p_we = 1'b1; p_waddr = h_rdata; p_wdata = '0;
				end
				if ((cmd_q == CMD_ADD && id_ok_q && !present
						&& fill_q != POS_W'(NUM_IDS))
						|| (cmd_q == CMD_UPDATE && present)) begin
					k_we = 1'b1;
				end
				if (cmd_q == CMD_CLEAR) begin
					h_raddr = POS_W'(1);
				end
			end
			S_TO_LAST: begin
				k_raddr = h_rdata;
			end
			S_DN_CHK: begin
				h_raddr = child[POS_W-1:0];
			end
			S_DN_A: begin
				h_raddr = child_nx[POS_W-1:0];
				k_raddr = h_rdata;
			end
			S_DN_B: begin
				k_raddr = h_rdata;
			end
			S_DN_C: begin
				if (!(ekey_q < ch_key)) begin
					h_we = 1'b1; h_wdata = ch_id;
					p_we = 1'b1; p_waddr = ch_id;
				end
			end
			S_DN_L1: begin
				k_raddr = h_rdata;
			end
			S_DN_L2: begin
				if (k_rdata < ekey_q) begin
					h_we = 1'b1; h_wdata = a_q;
					p_we = 1'b1; p_waddr = a_q;
				end
			end
			S_UP_CHK: begin
				h_raddr = pos_q >> 1;
			end
			S_UP_P: begin
				k_raddr = h_rdata;
			end
			S_UP_K: begin
				if (ekey_q < k_rdata) begin
					h_we = 1'b1; h_wdata = a_q;
					p_we = 1'b1; p_waddr = a_q;
				end
			end
			S_PLACE: begin
				h_we = 1'b1;
				p_we = 1'b1;
			end
			S_FIN: begin
				h_raddr = idx_q[POS_W-1:0];
				// Clear pipeline: the element read last cycle leaves the position map.
				if (cmd_q == CMD_CLEAR && rdv_s1) begin
					p_we = 1'b1; p_waddr = h_rdata; p_wdata = '0;
				end
			end
			default: begin
			end
		endcase
	end

	// Command sequencer with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			idx_q       <= '0;
			fill_q      <= '0;
			upd_q       <= 1'b0;
			rdv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					idx_q <= idx_q + (POS_W+1)'(1);
					if (idx_q == (POS_W+1)'(NUM_IDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						cmd_q    <= in_data.command;
						id_q     <= ID_W'(in_data.element_id);
						id_ok_q  <= 32'(in_data.element_id) < NUM_IDS;
						key_q    <= KEY_BITS'(in_data.priority_key);
						popped_q <= '0;
						upd_q    <= 1'b0;
						state_q  <= S_DEC;
					end
				end
				S_DEC: begin
					st_q    <= ST_DONE;
					lim_q   <= fill_q - POS_W'(1);
					del_q   <= id_q;
					state_q <= S_FIN;
					case (cmd_q)
						CMD_ADD: begin
							if (!id_ok_q || present) begin
								st_q <= ST_IGNORED;
							end else if (fill_q == POS_W'(NUM_IDS)) begin
								st_q <= ST_FULL;
							end else begin
								fill_q  <= fill_q + POS_W'(1);
								pos_q   <= fill_q + POS_W'(1);
								e_q     <= id_q;
								ekey_q  <= key_q;
								state_q <= S_UP_CHK;
							end
						end
						CMD_REMOVE: begin
							if (!present) begin
								st_q <= ST_IGNORED;
							end else begin
								fill_q  <= fill_q - POS_W'(1);
								pos_q   <= p_rdata;
								state_q <= S_TO_LAST;
							end
						end
						CMD_POP: begin
							if (fill_q == '0) begin
								st_q <= ST_EMPTY;
							end else begin
								fill_q   <= fill_q - POS_W'(1);
								popped_q <= h_rdata;
								del_q    <= h_rdata;
								pos_q    <= POS_W'(1);
								state_q  <= S_TO_LAST;
							end
						end
						CMD_UPDATE: begin
							if (!present) begin
								st_q <= ST_IGNORED;
							end else begin
								pos_q <= p_rdata;
								if (p_rdata == fill_q) begin
									e_q     <= id_q;
									ekey_q  <= key_q;
									state_q <= S_UP_CHK;
								end else begin
									// Sift the last element into the slot, then reinsert at the end.
									upd_q   <= 1'b1;
									state_q <= S_TO_LAST;
								end
							end
						end
						CMD_CLEAR: begin
							idx_q  <= (POS_W+1)'(1);
							rdv_s1 <= 1'b0;
						end
						default: begin
							st_q <= ST_IGNORED;
						end
					endcase
				end
				S_TO_LAST: begin
					e_q <= h_rdata;
					if (h_rdata == del_q) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_GET_EK;
					end
				end
				S_GET_EK: begin
					ekey_q  <= k_rdata;
					state_q <= S_DN_CHK;
				end
				S_DN_CHK: begin
					if (child < lim_x) begin
						state_q <= S_DN_A;
					end else if (child == lim_x) begin
						state_q <= S_DN_L1;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_DN_A: begin
					a_q     <= h_rdata;
					state_q <= S_DN_B;
				end
				S_DN_B: begin
					b_q     <= h_rdata;
					ka_q    <= k_rdata;
					state_q <= S_DN_C;
				end
				S_DN_C: begin
					if (ekey_q < ch_key) begin
						state_q <= S_PLACE;
					end else begin
						pos_q   <= ch_pos;
						state_q <= S_DN_CHK;
					end
				end
				S_DN_L1: begin
					a_q     <= h_rdata;
					state_q <= S_DN_L2;
				end
				S_DN_L2: begin
					if (k_rdata < ekey_q) begin
						pos_q <= child[POS_W-1:0];
					end
					state_q <= S_PLACE;
				end
				S_UP_CHK: begin
					if (pos_q <= POS_W'(1)) begin
						state_q <= S_PLACE;
					end else begin
						state_q <= S_UP_P;
					end
				end
				S_UP_P: begin
					a_q     <= h_rdata;
					state_q <= S_UP_K;
				end
				S_UP_K: begin
					if (ekey_q < k_rdata) begin
						pos_q   <= pos_q >> 1;
						state_q <= S_UP_CHK;
					end else begin
						state_q <= S_PLACE;
					end
				end
				S_PLACE: begin
					if (upd_q) begin
						upd_q   <= 1'b0;
						e_q     <= id_q;
						ekey_q  <= key_q;
						pos_q   <= fill_q;
						state_q <= S_UP_CHK;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (cmd_q == CMD_CLEAR && (idx_q <= {1'b0, fill_q} || rdv_s1)) begin
						rdv_s1 <= idx_q <= {1'b0, fill_q};
						if (idx_q <= {1'b0, fill_q}) begin
							idx_q <= idx_q + (POS_W+1)'(1);
						end
					end else if (!out_valid_q || out_ready) begin
						out_q.popped_id     <= ID_FIELD_W'(popped_q);
						out_q.status        <= st_q;
						out_q.element_count <= (cmd_q == CMD_CLEAR) ? '0 : COUNT_W'(fill_q);
						if (cmd_q == CMD_CLEAR) begin
							fill_q <= '0;
						end
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hdl/imh_checker.sv =====
// Port-level checker for the indexed min-heap and its bind to the top level.
module imh_checker #(
	parameter int NUM_IDS = 1024
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input imh_pkg::imh_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input imh_pkg::imh_out_t out_data
);

	import imh_pkg::*;

	// One command at a time: after an input transfer the block is busy.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a command was in progress");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.element_count <= COUNT_W'(NUM_IDS))
		else $error("element count above capacity");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_EMPTY |->
			out_data.element_count == '0 && out_data.popped_id == '0)
		else $error("empty pop with nonzero count or element");

	a_full_add: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status == ST_FULL |->
			out_data.element_count == COUNT_W'(NUM_IDS))
		else $error("full status below capacity");

	a_popped_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.popped_id != '0 |-> out_data.status == ST_DONE)
		else $error("popped element on a command that did not complete");

endmodule

bind indexed_min_heap imh_checker #(.NUM_IDS(NUM_IDS)) u_imh_checker (.*);
